>>> src/four_switch_debounce_reporter_assert.svh
// Assertion macros for the four-switch debounce reporter checker.
// Depends on nothing; included by the checker file only.
`ifndef FOUR_SWITCH_DEBOUNCE_REPORTER_ASSERT_SVH
`define FOUR_SWITCH_DEBOUNCE_REPORTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define FSDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define FSDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/fsdr_pkg.sv
// Shared types and constants for the four-switch debounce reporter.
// No dependencies; imported by fsdr_core, fsdr_out_queue and the top level.
package fsdr_pkg;

    // Switches carried by the level and report fields
    localparam int FIELD_SW = 4;
    // Settle counter and debounce time width
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 7'd7;
    localparam logic [CNT_W-1:0] COUNT_ONE = 7'd1;

    // Item function codes
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Reports produced by one tick, one slot per switch
    typedef struct packed {
        logic [FIELD_SW-1:0]               mask;
        logic [FIELD_SW-1:0][FIELD_SW-1:0] reports;
    } t_batch;

endpackage

>>> src/fsdr_core.sv
// Switch state and settle counters; computes the state update and report batch
// for one accepted beat. Depends on fsdr_pkg.
module fsdr_core import fsdr_pkg::*; #(
    parameter int NUM_SWITCHES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_func,
    input  logic [FIELD_SW-1:0] i_switch_levels,
    input  logic [CNT_W-1:0]    i_debounce_time,
    output t_batch              o_batch
);

    localparam int P_ACT = (NUM_SWITCHES > FIELD_SW) ? FIELD_SW : NUM_SWITCHES;

    logic [P_ACT-1:0]            r_state;
    logic [P_ACT-1:0]            n_state;
    logic [P_ACT-1:0][CNT_W-1:0] r_count;
    logic [P_ACT-1:0][CNT_W-1:0] n_count;

    // Per-switch update: poll arms idle counters, tick counts down or cancels
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_batch = '0;
        for (int i = 0; i < P_ACT; i++) begin
            if (i_func == FUNC_POLL) begin
                if (r_count[i] == '0 && r_state[i] != i_switch_levels[i]) begin
                    n_state[i] = i_switch_levels[i];
                    n_count[i] = i_debounce_time;
                end
            end else if (r_count[i] != '0) begin
                if (r_state[i] == i_switch_levels[i]) begin
                    n_count[i] = r_count[i] - COUNT_ONE;
                    o_batch.mask[i] = (r_count[i] == COUNT_ONE);
                end else begin
                    n_state[i] = i_switch_levels[i];
                    n_count[i] = '0;
                end
            end
        end
        // Report for switch i sees updates of switches 0..i only
        for (int i = 0; i < P_ACT; i++) begin
            for (int j = 0; j < P_ACT; j++) begin
                o_batch.reports[i][j] = (j <= i) ? ~n_state[j] : ~r_state[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '1;
            r_count <= '0;
        end else if (i_load) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

>>> src/fsdr_out_queue.sv
// Holds the report batch of one tick and drains it into the output register,
// one beat per cycle unless the receiver stalls. Depends on fsdr_pkg.
module fsdr_out_queue import fsdr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_batch              i_batch,
    input  logic                i_out_ready,
    output logic                o_load_ok,
    output logic                o_valid,
    output logic [FIELD_SW-1:0] o_report_byte,
    output logic                o_last_report
);

    localparam int IDX_W = $clog2(FIELD_SW);

    logic [FIELD_SW-1:0]               r_mask;
    logic [FIELD_SW-1:0][FIELD_SW-1:0] r_reps;
    logic                              r_valid;
    logic [FIELD_SW-1:0]               r_report;
    logic                              r_last;

    logic [IDX_W-1:0]    w_idx;
    logic [FIELD_SW-1:0] w_rest;
    logic [FIELD_SW-1:0] n_mask;
    logic                w_take;

    // Pick the lowest pending report; move it when the output slot frees up
    always_comb begin
        w_idx = '0;
        for (int i = FIELD_SW - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_idx = IDX_W'(i);
            end
        end
        w_rest        = r_mask;
        w_rest[w_idx] = 1'b0;
        w_take        = (r_mask != '0) && (!r_valid || i_out_ready);
        n_mask        = w_take ? w_rest : r_mask;
        o_load_ok     = (n_mask == '0);
    end

    // Pending mask and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= i_load ? i_batch.mask : n_mask;
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_reps <= i_batch.reports;
        end
        if (w_take) begin
            r_report <= r_reps[w_idx];
            r_last   <= (w_rest == '0);
        end
    end

    assign o_valid       = r_valid;
    assign o_report_byte = r_report;
    assign o_last_report = r_last;

endmodule

>>> src/four_switch_debounce_reporter.sv
// Top level of the four-switch debounce reporter: config register and glue.
// Depends on fsdr_pkg, fsdr_core and fsdr_out_queue.
//
// Input channel (i_valid/o_ready) carries poll beats (i_func = 0) and tick
// beats (i_func = 1) with the four switch levels. Output channel
// (o_valid/i_ready) carries reports: the inverted switch states and a flag on
// the last report of a tick. i_cfg_we writes the 7-bit debounce time at once.
// A tick's first report passes through the pending mask and then the output
// register; further reports of that tick follow one per cycle while i_ready
// is high. Throughput: one beat per cycle when a tick yields at most one
// report and i_ready is high; a tick with several reports holds o_ready low
// while its batch drains into the output register. Polls add no reports.
// Reset clears the counters, sets all switch states to released and the
// debounce time to 7; no report is pending afterwards.
// When the receiver stalls, the current report holds on the output; polls and
// ticks without reports keep flowing, and o_ready drops as soon as a tick's
// reports are queued behind the held beat.
module four_switch_debounce_reporter import fsdr_pkg::*; #(
    parameter int NUM_SWITCHES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic [FIELD_SW-1:0] i_switch_levels,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [FIELD_SW-1:0] o_report_byte,
    output logic                o_last_report,
    input  logic                i_cfg_we,
    input  logic [CNT_W-1:0]    i_cfg_wdata
);

    logic [CNT_W-1:0] r_debounce_time;
    logic             w_accept;
    logic             w_load_ok;
    t_batch           w_batch;

    // Debounce time register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            r_debounce_time <= i_cfg_wdata;
        end
    end

    assign o_ready  = w_load_ok;
    assign w_accept = i_valid && w_load_ok;

    fsdr_core #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_accept),
        .i_func          (i_func),
        .i_switch_levels (i_switch_levels),
        .i_debounce_time (r_debounce_time),
        .o_batch         (w_batch)
    );

    fsdr_out_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_batch       (w_batch),
        .i_out_ready   (i_ready),
        .o_load_ok     (w_load_ok),
        .o_valid       (o_valid),
        .o_report_byte (o_report_byte),
        .o_last_report (o_last_report)
    );

endmodule

>>> src/fsdr_checker.sv
// Port-level checks for the four-switch debounce reporter, bound to the top.
// Depends on four_switch_debounce_reporter_assert.svh.
`include "four_switch_debounce_reporter_assert.svh"

module fsdr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [3:0] o_report_byte,
    input logic       o_last_report
);

    // A stalled report beat holds
    `FSDR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_report_byte) && $stable(o_last_report), "report beat changed while stalled")

    // Input stalls only while reports are queued, so a report is out next cycle
    `FSDR_ASSERT_NEXT(a_stall_has_work, i_clk, i_rst_n, !o_ready, o_valid, "input stalled with no report coming")

    // Reports of one tick come back to back
    `FSDR_ASSERT_NEXT(a_burst_cont, i_clk, i_rst_n, o_valid && i_ready && !o_last_report, o_valid, "gap inside the reports of one tick")

    // More reports of the tick are queued behind a stalled non-last beat
    `FSDR_ASSERT_NOW(a_busy_mid_tick, i_clk, i_rst_n, o_valid && !i_ready && !o_last_report, !o_ready, "input taken while a tick is unfinished")

endmodule

bind four_switch_debounce_reporter fsdr_checker u_fsdr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_report_byte (o_report_byte),
    .o_last_report (o_last_report)
);

>>> verif/four_switch_debounce_reporter_tb.sv
// Testbench for four_switch_debounce_reporter: directed and random poll/tick beats.
// A local switch-state tracker predicts every report. Needs fsdr_pkg and the RTL.
module four_switch_debounce_reporter_tb;
    import fsdr_pkg::*;

    localparam int CYCLE_LIMIT   = 150000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [FIELD_SW-1:0] bits;
        logic                last;
    } report_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_func;
    logic [FIELD_SW-1:0] i_switch_levels;
    logic                o_valid;
    logic                i_ready;
    logic [FIELD_SW-1:0] o_report_byte;
    logic                o_last_report;
    logic                i_cfg_we;
    logic [CNT_W-1:0]    i_cfg_wdata;

    // Tracker state: stored levels, settle counters, debounce time
    logic [FIELD_SW-1:0] sw_state;
    logic [CNT_W-1:0]    settle_cnt [FIELD_SW];
    logic [CNT_W-1:0]    debounce_len;
    report_t             expected_reports [$];

    int errors;
    int cycle_count;
    int beats_sent;
    int ticks_sent;
    int reports_seen;
    int burst_left;
    int ready_phase;
    int stall_mode;

    four_switch_debounce_reporter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_switch_levels (i_switch_levels),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_report_byte   (o_report_byte),
        .o_last_report   (o_last_report),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("four_switch_debounce_reporter_tb: errors");
            $finish;
        end
    end

    // Receiver back-pressure: always ready, random, or periodic long stalls
    always @(negedge i_clk) begin
        ready_phase++;
        if (ready_phase % 48 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            default: i_ready <= ((ready_phase % 9) > 4);
        endcase
    end

    // Compare each accepted report beat with the oldest prediction
    always @(posedge i_clk) begin
        report_t exp_rep;
        if (i_rst_n && o_valid && i_ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected report byte=%h last=%b", $time,
                         o_report_byte, o_last_report);
            end else begin
                exp_rep = expected_reports.pop_front();
                if (o_report_byte !== exp_rep.bits) begin
                    errors++;
                    $display("%0t: report_byte expected %h got %h", $time,
                             exp_rep.bits, o_report_byte);
                end
                if (o_last_report !== exp_rep.last) begin
                    errors++;
                    $display("%0t: last_report expected %b got %b", $time,
                             exp_rep.last, o_last_report);
                end
            end
        end
    end

    function automatic void reset_tracker();
        sw_state     = '1;
        debounce_len = DEBOUNCE_RESET;
        for (int i = 0; i < FIELD_SW; i++)
            settle_cnt[i] = '0;
    endfunction

    // Advance the switch tracker by one accepted beat; queue the reports of a tick
    function automatic void track_switches(logic func, logic [FIELD_SW-1:0] lv);
        report_t batch [FIELD_SW];
        int n;
        n = 0;
        if (func == FUNC_POLL) begin
            for (int i = 0; i < FIELD_SW; i++) begin
                if (settle_cnt[i] == '0 && sw_state[i] != lv[i]) begin
                    sw_state[i]   = lv[i];
                    settle_cnt[i] = debounce_len;
                end
            end
            return;
        end
        for (int i = 0; i < FIELD_SW; i++) begin
            if (settle_cnt[i] != '0) begin
                if (sw_state[i] == lv[i]) begin
                    settle_cnt[i] = settle_cnt[i] - COUNT_ONE;
                    if (settle_cnt[i] == '0) begin
                        batch[n].bits = ~sw_state;
                        batch[n].last = 1'b0;
                        n++;
                    end
                end else begin
                    // bounce: adopt the level, drop the count
                    sw_state[i]   = lv[i];
                    settle_cnt[i] = '0;
                end
            end
        end
        for (int j = 0; j < n; j++) begin
            batch[j].last = (j == n - 1);
            expected_reports.push_back(batch[j]);
        end
    endfunction

    // Drive one beat from a falling edge, hold until accepted, return at a falling edge
    task automatic send_beat(input logic func, input logic [FIELD_SW-1:0] lv);
        i_valid         <= 1'b1;
        i_func          <= func;
        i_switch_levels <= lv;
        do
            @(posedge i_clk);
        while (!o_ready);
        track_switches(func, lv);
        beats_sent++;
        if (func == FUNC_TICK)
            ticks_sent++;
        @(negedge i_clk);
    endtask

    // Send a beat within the current burst; open a gap when the burst runs out
    task automatic issue(input logic func, input logic [FIELD_SW-1:0] lv);
        int gap;
        send_beat(func, lv);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stop sending, wait for every predicted report, then let the pipe empty
    task automatic drain_reports();
        i_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_debounce(input logic [CNT_W-1:0] value);
        drain_reports();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        debounce_len = value;
    endtask

    // Reset time: all switches press together, all four report in one tick
    task automatic test_reset_debounce();
        issue(FUNC_TICK, 4'b1111);
        issue(FUNC_POLL, 4'b0000);
        repeat (7) issue(FUNC_TICK, 4'b0000);
    endtask

    // Bounce on switches 0 and 2 cancels them; 1 and 3 still report
    task automatic test_bounce_cancel();
        issue(FUNC_POLL, 4'b1111);
        repeat (7) issue(FUNC_TICK, 4'b1010);
        issue(FUNC_TICK, 4'b1010);
    endtask

    // Shortest time reports on the first tick; zero time never reports
    task automatic test_time_extremes();
        write_debounce(7'd1);
        issue(FUNC_POLL, 4'b0110);
        issue(FUNC_TICK, 4'b0110);
        write_debounce(7'd0);
        issue(FUNC_POLL, 4'b1001);
        issue(FUNC_TICK, 4'b1001);
        issue(FUNC_POLL, 4'b0000);
        issue(FUNC_TICK, 4'b0000);
    endtask

    // Poll a new target, then hold it for about the debounce time with rare bounces
    task automatic settle_sequence();
        logic [FIELD_SW-1:0] target;
        logic [FIELD_SW-1:0] lv;
        int n;
        target = FIELD_SW'($urandom_range(0, 15));
        issue(FUNC_POLL, target);
        n = debounce_len + $urandom_range(0, 2);
        if ($urandom_range(0, 5) == 0)
            n = $urandom_range(0, n);
        for (int k = 0; k < n; k++) begin
            lv = target;
            if ($urandom_range(0, 11) == 0)
                lv[$urandom_range(0, FIELD_SW - 1)] ^= 1'b1;
            issue(FUNC_TICK, lv);
        end
    endtask

    task automatic test_random(input logic [CNT_W-1:0] value, input int beats);
        int stop_at;
        write_debounce(value);
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 3) != 0)
                settle_sequence();
            else
                repeat ($urandom_range(1, 3))
                    issue(1'($urandom_range(0, 1)), FIELD_SW'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        errors      = 0;
        cycle_count = 0;
        beats_sent  = 0;
        ticks_sent  = 0;
        reports_seen = 0;
        ready_phase = 0;
        stall_mode  = 0;
        burst_left  = 4;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_func          = FUNC_POLL;
        i_switch_levels = '1;
        i_ready         = 1'b1;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        reset_tracker();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_debounce();
        test_bounce_cancel();
        test_time_extremes();
        test_random(7'd1, 60);
        test_random(7'd4, 70);
        test_random(7'd127, 100);
        test_random(CNT_W'($urandom_range(2, 10)), 60);
        drain_reports();

        if (expected_reports.size() != 0) begin
            errors++;
            $display("%0t: %0d predicted reports never arrived", $time,
                     expected_reports.size());
        end
        $display("Covered %0d beats (%0d ticks) and %0d reports,", beats_sent,
                 ticks_sent, reports_seen);
        $display("debounce times 0, 1, 4, 7, 127 and a random short one.");
        if (errors == 0)
            $display("four_switch_debounce_reporter_tb: clean");
        else
            $display("four_switch_debounce_reporter_tb: errors");
        $finish;
    end

endmodule
